### design/trap_pkg.sv
// Shared types, constants and helpers for the typed register access parser.
package trap_pkg;

  localparam int BANK_DEPTH = 256;
  localparam int IDX_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = Q_PTR_W + 1;

  localparam logic [7:0] MODE_READ  = 8'd0;
  localparam logic [7:0] MODE_WRITE = 8'd1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] access_mode;
    logic       end_of_message;
  } req_t;

  typedef struct packed {
    logic [7:0] answer_byte;
    logic       answer_last;
  } ans_t;

  typedef enum logic [1:0] {
    OP_ECHO  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_kind_t;

  // One classified beat handed from the parser to the register side.
  typedef struct packed {
    op_kind_t         kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] addr;
    logic [1:0]       lane;
    logic             hit;
    logic             last;
  } op_t;

  function automatic logic [2:0] value_len(input logic [7:0] t);
    logic [2:0] n;
    begin
      case (t)
        8'd1, 8'd2:       n = 3'd1;
        8'd3, 8'd4:       n = 3'd2;
        8'd5, 8'd6, 8'd7: n = 3'd4;
        default:          n = 3'd0;
      endcase
      return n;
    end
  endfunction

endpackage

### design/typed_register_access_parser_core.sv
// Typed register access parser: top level.
// Path: a read-mode beat passes through the parser queue and the bank read register
// into the result queue. Input takes one payload byte per cycle unless full.
// The single bank port takes one beat per cycle; reads wait for result-queue room.
// Reset (rst, synchronous): parser expects a type byte, queues empty, all bank
// registers read as zero through per-entry written flags; no clearing pass.
module typed_register_access_parser_core
  import trap_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t request,
  output logic empty,
  input  logic pop,
  output ans_t answer
);

  logic take;
  logic op_push, op_pop, op_full, op_empty;
  op_t  op_in, op_out;

  assign full = op_full;
  assign take = push && !op_full;

  trap_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .request (request),
    .op_push (op_push),
    .op      (op_in)
  );

  trap_opq u_opq (
    .clk   (clk),
    .rst   (rst),
    .push  (op_push),
    .wr_op (op_in),
    .pop   (op_pop),
    .rd_op (op_out),
    .full  (op_full),
    .empty (op_empty)
  );

  trap_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (op_out),
    .op_empty (op_empty),
    .op_pop   (op_pop),
    .pop      (pop),
    .empty    (empty),
    .answer   (answer)
  );

endmodule

### design/trap_front.sv
// Parser front end: tracks entry framing and classifies each accepted byte.
module trap_front
  import trap_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  req_t request,
  output logic op_push,
  output op_t  op
);

  typedef enum logic [3:0] {
    PH_TYPE   = 4'b0001,
    PH_IDX_LO = 4'b0010,
    PH_IDX_HI = 4'b0100,
    PH_VALUE  = 4'b1000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  entry_type, entry_type_next;
  logic [15:0] entry_index, entry_index_next;
  logic [2:0]  left, left_next;
  logic [1:0]  pos, pos_next;
  logic [2:0]  n;
  logic        hit;
  logic        is_read, is_write;

  assign hit      = {1'b0, entry_index} < 17'(BANK_DEPTH);
  assign is_read  = request.access_mode == MODE_READ;
  assign is_write = request.access_mode == MODE_WRITE;
  assign n        = value_len(entry_type);

  always_comb begin
    phase_next       = phase;
    entry_type_next  = entry_type;
    entry_index_next = entry_index;
    left_next        = left;
    pos_next         = pos;
    case (phase)
      PH_TYPE: begin
        entry_type_next = request.payload_byte;
        phase_next      = PH_IDX_LO;
      end
      PH_IDX_LO: begin
        entry_index_next = {entry_index[15:8], request.payload_byte};
        phase_next       = PH_IDX_HI;
      end
      PH_IDX_HI: begin
        entry_index_next = {request.payload_byte, entry_index[7:0]};
        left_next        = n;
        pos_next         = 2'd0;
        phase_next       = (n != 3'd0) ? PH_VALUE : PH_TYPE;
      end
      default: begin
        if (left != 3'd0) left_next = left - 3'd1;
        pos_next = pos + 2'd1;
        if (left_next == 3'd0) phase_next = PH_TYPE;
      end
    endcase
    if (request.end_of_message) begin
      phase_next = PH_TYPE;
      left_next  = 3'd0;
      pos_next   = 2'd0;
    end
  end

  always_comb begin
    op.data = request.payload_byte;
    op.addr = entry_index[IDX_W-1:0];
    op.lane = pos;
    op.hit  = hit;
    op.last = request.end_of_message;
    if (phase == PH_VALUE) begin
      op.kind = is_read ? OP_READ : OP_WRITE;
      op_push = take && (is_read || (is_write && hit));
    end else begin
      op.kind = OP_ECHO;
      op_push = take && is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TYPE;
      entry_type  <= 8'd0;
      entry_index <= 16'd0;
      left        <= 3'd0;
      pos         <= 2'd0;
    end else if (take) begin
      phase       <= phase_next;
      entry_type  <= entry_type_next;
      entry_index <= entry_index_next;
      left        <= left_next;
      pos         <= pos_next;
    end
  end

endmodule

### design/trap_opq.sv
// Short queue of classified beats between the parser and the register side.
module trap_opq
  import trap_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  wr_op,
  input  logic pop,
  output op_t  rd_op,
  output logic full,
  output logic empty
);

  op_t                slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr, rptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push, do_pop;

  assign full    = count == Q_CNT_W'(Q_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_op   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= wr_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      count <= count + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end
  end

endmodule

### design/trap_back.sv
// Register side: bank access, answer byte selection and result queue.
module trap_back
  import trap_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  op_t  op,
  input  logic op_empty,
  output logic op_pop,
  input  logic pop,
  output logic empty,
  output ans_t answer
);

  logic [3:0][7:0]     bank [BANK_DEPTH];
  logic [BANK_DEPTH-1:0] written;

  // stage 2 (after bank read)
  logic               s2_v;
  op_kind_t           s2_kind;
  logic [7:0]         s2_data;
  logic [1:0]         s2_lane;
  logic               s2_hit;
  logic               s2_last;
  logic [3:0][7:0]    rd_word;
  logic               rd_written;
  ans_t               s2_ans;

  // result queue
  ans_t               res [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr, rptr;
  logic [Q_CNT_W-1:0] count;
  logic               room, wr_en, do_pop;

  // reserve a slot for the beat already in stage 2
  assign room   = ({1'b0, count} + (Q_CNT_W + 1)'(s2_v)) < (Q_CNT_W + 1)'(Q_DEPTH);
  assign op_pop = !op_empty && (op.kind == OP_WRITE || room);
  assign wr_en  = op_pop && op.kind == OP_WRITE;

  // Never-written entries read as zero; the first write zero-fills other lanes.
  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      if (wr_en && (op.lane == 2'(l) || !written[op.addr])) begin
        bank[op.addr][l] <= (op.lane == 2'(l)) ? op.data : 8'd0;
      end
    end
    if (op_pop) begin
      rd_word    <= bank[op.addr];
      rd_written <= written[op.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) written <= '0;
    else if (wr_en) written[op.addr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else s2_v <= op_pop && op.kind != OP_WRITE;
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      s2_kind <= op.kind;
      s2_data <= op.data;
      s2_lane <= op.lane;
      s2_hit  <= op.hit;
      s2_last <= op.last;
    end
  end

  always_comb begin
    s2_ans.answer_last = s2_last;
    if (s2_kind == OP_READ) begin
      s2_ans.answer_byte = (s2_hit && rd_written) ? rd_word[s2_lane] : 8'd0;
    end else begin
      s2_ans.answer_byte = s2_data;
    end
  end

  assign empty  = count == '0;
  assign do_pop = pop && !empty;
  assign answer = res[rptr];

  always_ff @(posedge clk) begin
    if (s2_v) res[wptr] <= s2_ans;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (s2_v)   wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      count <= count + Q_CNT_W'(s2_v) - Q_CNT_W'(do_pop);
    end
  end

endmodule

### design/trap_checker.sv
// Port-level checks for the typed register access parser, bound to the top level.
module trap_checker
  import trap_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input ans_t answer
);

  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result side not empty after reset");

  a_not_full_after_reset: assert property (@(posedge clk) $past(rst) |-> !full)
    else $error("input side full after reset");

  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without a pushed beat");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(answer)))
    else $error("waiting result changed or vanished");

endmodule

bind typed_register_access_parser_core trap_checker u_trap_checker (
  .clk     (clk),
  .rst     (rst),
  .push    (push),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .answer  (answer)
);

### tb/parser_scoreboard_pkg.sv
// Answer prediction and checking for the typed register access parser testbench.
package parser_scoreboard_pkg;
  import trap_pkg::*;

  // Any mode other than read or write only walks the parser.
  localparam logic [7:0] MODE_PARSE_ONLY = 8'hFF;

  typedef enum logic [1:0] {
    WANT_TYPE,
    WANT_IDX_LO,
    WANT_IDX_HI,
    WANT_VALUE
  } entry_phase_e;

  class answer_scoreboard;
    entry_phase_e phase;
    logic [7:0]   entry_type;
    logic [15:0]  entry_index;
    logic [2:0]   bytes_left;
    logic [1:0]   lane;
    logic [31:0]  bank [BANK_DEPTH];
    ans_t         answers_due[$];
    int           beats_in;
    int           answers_checked;
    int           mismatches;

    function new();
      phase           = WANT_TYPE;
      entry_type      = '0;
      entry_index     = '0;
      bytes_left      = '0;
      lane            = '0;
      beats_in        = 0;
      answers_checked = 0;
      mismatches      = 0;
      foreach (bank[i]) bank[i] = '0;
    endfunction

    function logic [2:0] bytes_for_type(logic [7:0] t);
      if (t >= 8'd5 && t <= 8'd7) return 3'd4;
      if (t >= 8'd3 && t <= 8'd4) return 3'd2;
      if (t >= 8'd1 && t <= 8'd2) return 3'd1;
      return 3'd0;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH %s", $time, what);
      mismatches++;
    endtask

    // Advance the parser by one accepted beat; queue the answer a read beat owes.
    function void take_request(req_t r);
      logic [7:0] ans;
      logic       hit;
      ans_t       a;
      ans = r.payload_byte;
      beats_in++;
      case (phase)
        WANT_TYPE: begin
          entry_type = r.payload_byte;
          phase      = WANT_IDX_LO;
        end
        WANT_IDX_LO: begin
          entry_index[7:0] = r.payload_byte;
          phase            = WANT_IDX_HI;
        end
        WANT_IDX_HI: begin
          entry_index[15:8] = r.payload_byte;
          bytes_left        = bytes_for_type(entry_type);
          lane              = '0;
          phase             = (bytes_left != 0) ? WANT_VALUE : WANT_TYPE;
        end
        default: begin
          hit = (entry_index < BANK_DEPTH);
          if (r.access_mode == MODE_READ) begin
            ans = hit ? bank[entry_index][lane*8 +: 8] : 8'h00;
          end else if (r.access_mode == MODE_WRITE && hit) begin
            bank[entry_index][lane*8 +: 8] = r.payload_byte;
          end
          if (bytes_left != 0) bytes_left--;
          lane++;
          if (bytes_left == 0) phase = WANT_TYPE;
        end
      endcase
      if (r.end_of_message) begin
        phase      = WANT_TYPE;
        bytes_left = '0;
        lane       = '0;
      end
      if (r.access_mode == MODE_READ) begin
        a.answer_byte = ans;
        a.answer_last = r.end_of_message;
        answers_due.push_back(a);
      end
    endfunction

    task check_answer(ans_t got);
      ans_t want;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("unexpected answer byte %02h last %0b",
                                  got.answer_byte, got.answer_last));
        return;
      end
      want = answers_due.pop_front();
      answers_checked++;
      if (got.answer_byte !== want.answer_byte)
        report_mismatch($sformatf("answer_byte got %02h want %02h",
                                  got.answer_byte, want.answer_byte));
      if (got.answer_last !== want.answer_last)
        report_mismatch($sformatf("answer_last got %0b want %0b",
                                  got.answer_last, want.answer_last));
    endtask

    task check_leftover();
      if (answers_due.size() != 0)
        report_mismatch($sformatf("%0d answer bytes never arrived", answers_due.size()));
    endtask
  endclass

endpackage

### tb/tb.sv
// Top-level testbench for the typed register access parser.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trap_pkg::*;
  import parser_scoreboard_pkg::*;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS   = 390;
  localparam int DRAIN_CYCLES   = 10;

  logic clk;
  logic rst  = 1'b1;
  logic push = 1'b0;
  logic pop  = 1'b0;
  logic full;
  logic empty;
  req_t request = '0;
  ans_t answer;

  answer_scoreboard sb = new();

  req_t msg_q[$];
  int   beats_sent   = 0;
  int   burst_left   = 0;
  int   idle_cycles  = 0;
  bit   hold_off_req = 1'b0;

  typed_register_access_parser_core uut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .answer  (answer)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Monitor both sides and watch for lack of progress.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.take_request(request);
      if (pop && !empty) sb.check_answer(answer);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: random pop density in stretches, plus one long hold-off on request.
  initial begin : receiver
    int pop_pct;
    int pattern_left;
    pop_pct      = 100;
    pattern_left = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(8, 64);
          case ($urandom_range(0, 3))
            0:       pop_pct = 100;
            1:       pop_pct = 75;
            2:       pop_pct = 40;
            default: pop_pct = 10;
          endcase
        end
        pattern_left--;
        pop <= ($urandom_range(1, 100) <= pop_pct);
      end
    end
  end

  task automatic send_beat(input req_t r);
    push    <= 1'b1;
    request <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_msg();
    int gap;
    foreach (msg_q[k]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      send_beat(msg_q[k]);
      burst_left--;
    end
  endtask

  // Always waits on a falling clock edge before checking, so push is never lowered and raised in one step.
  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  function automatic void add_beat(logic [7:0] b, logic [7:0] m);
    msg_q.push_back('{payload_byte: b, access_mode: m, end_of_message: 1'b0});
  endfunction

  function automatic void close_msg();
    msg_q[msg_q.size()-1].end_of_message = 1'b1;
  endfunction

  function automatic logic [7:0] any_mode();
    case ($urandom_range(0, 2))
      0:       return MODE_READ;
      1:       return MODE_WRITE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_entry(logic [7:0] t, logic [15:0] idx, logic [7:0] m,
                                    logic [31:0] val, bit mixed);
    add_beat(t, mixed ? any_mode() : m);
    add_beat(idx[7:0], mixed ? any_mode() : m);
    add_beat(idx[15:8], mixed ? any_mode() : m);
    for (int i = 0; i < sb.bytes_for_type(t); i++)
      add_beat(val[i*8 +: 8], mixed ? any_mode() : m);
  endfunction

  function automatic void make_random_msg();
    int          sel;
    int          cut;
    logic [7:0]  msg_mode;
    logic [7:0]  typ;
    logic [15:0] idx;
    bit          mixed;
    msg_q.delete();
    sel = $urandom_range(0, 99);
    if (sel < 45) msg_mode = MODE_READ;
    else if (sel < 85) msg_mode = MODE_WRITE;
    else msg_mode = 8'($urandom_range(2, 255));
    mixed = ($urandom_range(0, 9) == 0);
    repeat ($urandom_range(1, 4)) begin
      sel = $urandom_range(0, 99);
      typ = (sel < 85) ? 8'($urandom_range(1, 7)) : 8'($urandom_range(0, 255));
      // mostly a few low indexes so reads land on registers that were written
      sel = $urandom_range(0, 99);
      if (sel < 60) idx = 16'($urandom_range(0, 7));
      else if (sel < 80) idx = 16'($urandom_range(0, BANK_DEPTH - 1));
      else if (sel < 95) idx = 16'($urandom_range(BANK_DEPTH, 65535));
      else idx = 16'hFFFF;
      add_entry(typ, idx, msg_mode, $urandom, mixed);
    end
    // some messages end in the middle of an entry
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, msg_q.size());
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end
    close_msg();
  endfunction

  initial begin : stimulus
    int rand_start;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full-width write of register 0 with extreme byte values
    msg_q.delete();
    add_entry(8'd7, 16'h0000, MODE_WRITE, 32'h5AA5_00FF, 1'b0);
    close_msg();
    send_msg();
    // read it back, then an unknown type at the top index, then an out-of-bank read
    msg_q.delete();
    add_entry(8'd5, 16'h0000, MODE_READ, 32'hFFFF_FFFF, 1'b0);
    add_entry(8'hFF, 16'hFFFF, MODE_READ, 32'h0, 1'b0);
    add_entry(8'd1, 16'h0100, MODE_READ, 32'h0000_0033, 1'b0);
    close_msg();
    send_msg();
    // mode changes beat by beat inside one entry
    msg_q.delete();
    add_beat(8'd4, MODE_READ);
    add_beat(8'h01, MODE_PARSE_ONLY);
    add_beat(8'h00, MODE_WRITE);
    add_beat(8'h80, MODE_WRITE);
    add_beat(8'h7F, MODE_READ);
    close_msg();
    send_msg();
    // message ends after the first of four value bytes
    msg_q.delete();
    add_beat(8'd6, MODE_WRITE);
    add_beat(8'h02, MODE_WRITE);
    add_beat(8'h00, MODE_WRITE);
    add_beat(8'h11, MODE_WRITE);
    close_msg();
    send_msg();
    wait_drained();

    // receiver holds off while a long read message backs up into the input
    hold_off_req = 1'b1;
    msg_q.delete();
    for (int k = 0; k < 4; k++)
      add_entry(8'd7, 16'(k), MODE_READ, $urandom, 1'b0);
    close_msg();
    send_msg();
    wait_drained();

    rand_start = beats_sent;
    while (beats_sent - rand_start < RANDOM_BEATS) begin
      make_random_msg();
      send_msg();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_leftover();

    $display("Summary: %0d payload bytes sent, %0d answer bytes checked, %0d mismatches",
             sb.beats_in, sb.answers_checked, sb.mismatches);
    $display("Covered read, write and parse-only beats, unknown types, out-of-bank indexes,");
    $display("truncated entries, per-beat mode changes and a full input stall.");
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### typed_register_access_parser_core.f
design/trap_pkg.sv
design/trap_front.sv
design/trap_opq.sv
design/trap_back.sv
design/typed_register_access_parser_core.sv
design/trap_checker.sv
tb/parser_scoreboard_pkg.sv
tb/tb.sv
